/* src/lbm_pkg.sv */
`default_nettype none
package lbm_pkg;

    localparam int DEF_GRID_X = 64;
    localparam int DEF_GRID_Y = 64;

    localparam int INV_TAU_W = 17;
    localparam logic [INV_TAU_W-1:0] INV_TAU_RESET = 17'd65536;

    localparam logic [62:0] ERR_CAP = {63{1'b1}};

    // request kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_ITER  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    localparam int NPOP = 5;

    typedef struct packed {
        logic req_load;
        logic cnt_rst;
        logic cnt_inc;
        logic clr_we;
        logic clr_src;
        logic src_wr;
        logic it_sum;
        logic it_col;
        logic it_wr;
        logic tot_clr;
        logic bank_flip;
        logic out_load;
    } lbm_cmd_t;

    typedef struct packed {
        logic       last_cell;
        logic [1:0] req_kind;
    } lbm_stat_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sh8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* src/lbm_ram.sv */
`default_nettype none
module lbm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

/* src/lbm_ctrl.sv */
`default_nettype none
module lbm_ctrl
    import lbm_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_req_type,
    output logic            m_valid,
    input  wire logic       m_ready,
    input  wire lbm_stat_t  stat,
    output lbm_cmd_t        cmd
);

    localparam logic [3:0] ST_INIT    = 4'd0;
    localparam logic [3:0] ST_IDLE    = 4'd1;
    localparam logic [3:0] ST_SRC_WR  = 4'd2;
    localparam logic [3:0] ST_RD_WAIT = 4'd3;
    localparam logic [3:0] ST_CLR     = 4'd4;
    localparam logic [3:0] ST_IT_RD   = 4'd5;
    localparam logic [3:0] ST_IT_SUM  = 4'd6;
    localparam logic [3:0] ST_IT_COL  = 4'd7;
    localparam logic [3:0] ST_IT_WR   = 4'd8;
    localparam logic [3:0] ST_FINISH  = 4'd9;

    logic [3:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        cmd          = '0;
        s_ready      = 1'b0;
        unique case (state_reg)
            ST_INIT: begin
                cmd.clr_we  = 1'b1;
                cmd.clr_src = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (stat.last_cell) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.req_load = 1'b1;
                    cmd.cnt_rst  = 1'b1;
                    cmd.tot_clr  = 1'b1;
                    unique case (s_req_type)
                        KIND_WRITE: state_next = ST_SRC_WR;
                        KIND_ITER:  state_next = ST_IT_RD;
                        KIND_READ:  state_next = ST_RD_WAIT;
                        default:    state_next = ST_CLR;
                    endcase
                end
            end
            ST_SRC_WR: begin
                cmd.src_wr = 1'b1;
                state_next = ST_FINISH;
            end
            ST_RD_WAIT: begin
                state_next = ST_FINISH;
            end
            ST_CLR: begin
                cmd.clr_we  = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (stat.last_cell) begin
                    state_next = ST_FINISH;
                end
            end
            ST_IT_RD: begin
                state_next = ST_IT_SUM;
            end
            ST_IT_SUM: begin
                cmd.it_sum = 1'b1;
                state_next = ST_IT_COL;
            end
            ST_IT_COL: begin
                cmd.it_col = 1'b1;
                state_next = ST_IT_WR;
            end
            ST_IT_WR: begin
                cmd.it_wr   = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (stat.last_cell) begin
                    cmd.bank_flip = 1'b1;
                    state_next    = ST_FINISH;
                end else begin
                    state_next = ST_IT_RD;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule
`default_nettype wire

/* src/lbm_datapath.sv */
`default_nettype none
module lbm_datapath
    import lbm_pkg::*;
#(
    parameter int GRID_X = DEF_GRID_X,
    parameter int GRID_Y = DEF_GRID_Y
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire lbm_cmd_t             cmd,
    output lbm_stat_t                 stat,
    input  wire logic [INV_TAU_W-1:0] inv_tau,
    input  wire logic [1:0]           s_req_type,
    input  wire logic [5:0]           s_cell_x,
    input  wire logic [5:0]           s_cell_y,
    input  wire logic signed [31:0]   s_source_value,
    output logic [1:0]                m_ack_kind,
    output logic signed [31:0]        m_density_value,
    output logic [62:0]               m_error_total
);

    localparam int CELLS = GRID_X * GRID_Y;
    localparam int AW    = $clog2(CELLS);
    localparam int XW    = $clog2(GRID_X);
    localparam int YW    = $clog2(GRID_Y);
    localparam int AW2   = AW + 12;

    // request
    logic [1:0]         req_kind_reg;
    logic [5:0]         req_x_reg, req_y_reg;
    logic signed [31:0] req_src_reg;
    logic [AW2-1:0]     req_addr_wide;
    logic [AW-1:0]      req_addr;
    logic               in_grid;

    // cell walk
    logic [AW-1:0] cnt_reg;
    logic [XW-1:0] x_reg;
    logic [YW-1:0] y_reg;
    logic          bank_reg;

    // arithmetic
    logic signed [31:0] rho_reg;
    logic signed [31:0] fnew_reg [NPOP];
    logic [63:0]        sq_reg;
    logic [62:0]        total_reg;

    logic [1:0]         out_kind_reg;
    logic signed [31:0] out_dens_reg;
    logic [62:0]        out_err_reg;

    // memories
    logic [31:0]   pop_rd    [2][NPOP];
    logic          pop_we    [2][NPOP];
    logic [AW-1:0] pop_waddr [NPOP];
    logic [31:0]   pop_wdata [NPOP];
    logic [AW-1:0] dest      [NPOP];
    logic signed [31:0] f    [NPOP];
    logic [31:0]   src_rd, dens_rd, past_rd;

    assign req_addr_wide = AW2'(req_y_reg) * AW2'(GRID_X) + AW2'(req_x_reg);
    assign req_addr      = req_addr_wide[AW-1:0];
    assign in_grid       = (32'(req_x_reg) < GRID_X) && (32'(req_y_reg) < GRID_Y);

    assign stat.last_cell = (cnt_reg == AW'(CELLS - 1));
    assign stat.req_kind  = req_kind_reg;

    // streaming targets with periodic wrap
    always_comb begin
        dest[0] = cnt_reg;
        dest[1] = (32'(x_reg) == GRID_X - 1) ? cnt_reg - AW'(GRID_X - 1) : cnt_reg + AW'(1);
        dest[2] = (32'(y_reg) == GRID_Y - 1) ? cnt_reg - AW'((GRID_Y - 1) * GRID_X)
                                              : cnt_reg + AW'(GRID_X);
        dest[3] = (x_reg == '0) ? cnt_reg + AW'(GRID_X - 1) : cnt_reg - AW'(1);
        dest[4] = (y_reg == '0) ? cnt_reg + AW'((GRID_Y - 1) * GRID_X)
                                : cnt_reg - AW'(GRID_X);
    end

    genvar gb, gp;
    generate
        for (gp = 0; gp < NPOP; gp++) begin : g_plane
            assign f[gp]         = $signed(bank_reg ? pop_rd[1][gp] : pop_rd[0][gp]);
            assign pop_waddr[gp] = cmd.clr_we ? cnt_reg : dest[gp];
            assign pop_wdata[gp] = cmd.clr_we ? 32'd0 : fnew_reg[gp];
            for (gb = 0; gb < 2; gb++) begin : g_bank
                assign pop_we[gb][gp] = (cmd.clr_we && (bank_reg == gb[0]))
                                     || (cmd.it_wr && (bank_reg != gb[0]));
                lbm_ram #(.WIDTH(32), .DEPTH(CELLS)) u_pop (
                    .aclk  (aclk),
                    .we    (pop_we[gb][gp]),
                    .waddr (pop_waddr[gp]),
                    .wdata (pop_wdata[gp]),
                    .raddr (cnt_reg),
                    .rdata (pop_rd[gb][gp])
                );
            end
        end
    endgenerate

    lbm_ram #(.WIDTH(32), .DEPTH(CELLS)) u_src (
        .aclk  (aclk),
        .we    ((cmd.clr_we && cmd.clr_src) || (cmd.src_wr && in_grid)),
        .waddr (cmd.clr_we ? cnt_reg : req_addr),
        .wdata (cmd.clr_we ? 32'd0 : req_src_reg),
        .raddr (cnt_reg),
        .rdata (src_rd)
    );

    lbm_ram #(.WIDTH(32), .DEPTH(CELLS)) u_dens (
        .aclk  (aclk),
        .we    (cmd.clr_we || cmd.it_wr),
        .waddr (cnt_reg),
        .wdata (cmd.clr_we ? 32'd0 : rho_reg),
        .raddr (req_addr),
        .rdata (dens_rd)
    );

    lbm_ram #(.WIDTH(32), .DEPTH(CELLS)) u_past (
        .aclk  (aclk),
        .we    (cmd.clr_we || cmd.it_wr),
        .waddr (cnt_reg),
        .wdata (cmd.clr_we ? 32'd0 : rho_reg),
        .raddr (cnt_reg),
        .rdata (past_rd)
    );

    // density of the cell
    logic signed [34:0] pop_sum;
    assign pop_sum = 35'(f[0]) + 35'(f[1]) + 35'(f[2]) + 35'(f[3]) + 35'(f[4]);

    // bgk collision, one lane per population
    logic signed [35:0] wrho  [NPOP];
    logic signed [35:0] delta [NPOP];
    logic signed [53:0] prod  [NPOP];
    logic signed [55:0] acc   [NPOP];
    logic signed [55:0] shr   [NPOP];
    logic signed [17:0] rate;
    logic signed [31:0] src_s;

    assign rate  = $signed({1'b0, inv_tau});
    assign src_s = $signed(src_rd);

    always_comb begin
        for (int p = 0; p < NPOP; p++) begin
            wrho[p]  = (p == 0) ? (36'(rho_reg) <<< 2) : 36'(rho_reg);
            delta[p] = wrho[p] - (36'(f[p]) <<< 3);
            prod[p]  = delta[p] * rate;
            acc[p]   = (56'(f[p]) <<< 19) + 56'(prod[p])
                     + ((p == 0) ? (56'(src_s) <<< 18) : (56'(src_s) <<< 16))
                     + 56'sh4_0000;
            shr[p]   = acc[p] >>> 19;
        end
    end

    // squared density change
    logic signed [32:0] dchg;
    logic [32:0]        dmag;
    logic [64:0]        tot_sum;

    assign dchg    = 33'(rho_reg) - 33'($signed(past_rd));
    assign dmag    = dchg[32] ? 33'(-dchg) : 33'(dchg);
    assign tot_sum = 65'(total_reg) + 65'(sq_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            x_reg    <= '0;
            y_reg    <= '0;
            bank_reg <= 1'b0;
        end else begin
            if (cmd.cnt_rst) begin
                cnt_reg <= '0;
                x_reg   <= '0;
                y_reg   <= '0;
            end else if (cmd.cnt_inc) begin
                cnt_reg <= stat.last_cell ? '0 : cnt_reg + AW'(1);
                if (32'(x_reg) == GRID_X - 1) begin
                    x_reg <= '0;
                    y_reg <= (32'(y_reg) == GRID_Y - 1) ? '0 : y_reg + YW'(1);
                end else begin
                    x_reg <= x_reg + XW'(1);
                end
            end
            if (cmd.bank_flip) begin
                bank_reg <= ~bank_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.req_load) begin
            req_kind_reg <= s_req_type;
            req_x_reg    <= s_cell_x;
            req_y_reg    <= s_cell_y;
            req_src_reg  <= s_source_value;
        end
        if (cmd.it_sum) begin
            rho_reg <= sat32(64'(pop_sum));
        end
        if (cmd.it_col) begin
            for (int p = 0; p < NPOP; p++) begin
                fnew_reg[p] <= sat32(64'(shr[p]));
            end
            sq_reg <= dmag[31:0] * dmag[31:0];
        end
        if (cmd.tot_clr) begin
            total_reg <= '0;
        end else if (cmd.it_wr) begin
            total_reg <= (tot_sum > 65'(ERR_CAP)) ? ERR_CAP : tot_sum[62:0];
        end
        if (cmd.out_load) begin
            out_kind_reg <= req_kind_reg;
            out_dens_reg <= (req_kind_reg == KIND_READ && in_grid) ? $signed(dens_rd) : '0;
            out_err_reg  <= (req_kind_reg == KIND_ITER) ? total_reg : '0;
        end
    end

    assign m_ack_kind      = out_kind_reg;
    assign m_density_value = out_dens_reg;
    assign m_error_total   = out_err_reg;

endmodule
`default_nettype wire

/* src/lattice_boltzmann_d2q5_step.sv */
`default_nettype none
// d2q5 lattice boltzmann engine on a periodic GRID_X by GRID_Y grid, q16.16 saturating
// arithmetic, one result word per request word. after reset a clearing pass over all
// GRID_X*GRID_Y cells zeroes the source, density and past-density grids and the current
// population bank before the first request word is taken (apb writes are taken
// throughout). a clear request walks every cell once; for an iterate request the
// sequencer visits each cell in four steps (read the five populations, sum density,
// collide all five lanes and square the density change, write the streamed
// populations to the other population bank). populations live in two ping-pong banks
// so streaming never overwrites unread data. inv_tau sits at byte address 0 of the
// apb port. a new request word is taken while the previous result word still waits
// at the output.
module lattice_boltzmann_d2q5_step
    import lbm_pkg::*;
#(
    parameter int GRID_X = DEF_GRID_X,
    parameter int GRID_Y = DEF_GRID_Y
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // request words
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_req_type,
    input  wire logic [5:0]         s_cell_x,
    input  wire logic [5:0]         s_cell_y,
    input  wire logic signed [31:0] s_source_value,
    // result words
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_ack_kind,
    output logic signed [31:0]      m_density_value,
    output logic [62:0]             m_error_total,
    // register port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic [INV_TAU_W-1:0] inv_tau_reg;
    lbm_cmd_t             cmd;
    lbm_stat_t            stat;

    // relaxation rate register, only word 0 is implemented
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inv_tau_reg <= INV_TAU_RESET;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            inv_tau_reg <= pwdata[INV_TAU_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : 32'(inv_tau_reg);

    // sequencer
    lbm_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    // grids, collision lanes, error accumulator and result register
    lbm_datapath #(
        .GRID_X (GRID_X),
        .GRID_Y (GRID_Y)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .inv_tau         (inv_tau_reg),
        .s_req_type      (s_req_type),
        .s_cell_x        (s_cell_x),
        .s_cell_y        (s_cell_y),
        .s_source_value  (s_source_value),
        .m_ack_kind      (m_ack_kind),
        .m_density_value (m_density_value),
        .m_error_total   (m_error_total)
    );

endmodule
`default_nettype wire

/* tb/tb_lattice_boltzmann_d2q5_step.sv */
`timescale 1ns / 1ps
module tb_lattice_boltzmann_d2q5_step
    import lbm_pkg::*;
();

    localparam int NX = 64;
    localparam int NY = 64;
    localparam int NCELL = NX * NY;
    // a few dozen iterate requests plus clears and stalls fit easily in this limit
    localparam int CYCLE_LIMIT = 10000000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_req_type = KIND_READ;
    logic [5:0] s_cell_x = '0;
    logic [5:0] s_cell_y = '0;
    logic signed [31:0] s_source_value = '0;

    logic m_valid;
    logic m_ready = 1'b0;
    logic [1:0] m_ack_kind;
    logic signed [31:0] m_density_value;
    logic [62:0] m_error_total;

    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    lattice_boltzmann_d2q5_step u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_req_type(s_req_type),
        .s_cell_x(s_cell_x), .s_cell_y(s_cell_y), .s_source_value(s_source_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_ack_kind(m_ack_kind),
        .m_density_value(m_density_value), .m_error_total(m_error_total),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #2 aclk = ~aclk;

    // one expected result word
    typedef struct {
        logic [1:0]  kind;
        logic [31:0] dens;
        logic [62:0] err;
    } ack_t;

    ack_t ack_q[$];
    int   fail_count = 0;
    int   cycle_count = 0;

    // shadow lattice state
    int          fpop[5][NCELL];
    int          fnext[NCELL];
    int          src_grid[NCELL];
    int          rho_grid[NCELL];
    int          rho_past[NCELL];
    logic [16:0] tau_rate = INV_TAU_RESET;

    // sender and receiver idling, percent of cycles
    int send_idle = 0;
    int recv_idle = 0;
    int recv_hold = 0;

    // cells written lately, so reads mostly hit live data
    int hot_cells[$];

    function automatic int clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return int'(v);
    endfunction

    function automatic void wipe_lattice();
        for (int c = 0; c < NCELL; c++) begin
            for (int p = 0; p < NPOP; p++) fpop[p][c] = 0;
            rho_grid[c] = 0;
            rho_past[c] = 0;
        end
    endfunction

    // full step: density, bgk collision, periodic streaming, squared change
    function automatic logic [62:0] lattice_step();
        longint          acc, w8, f, rho;
        longint unsigned total, mag, sq, cap;
        longint          diff;
        int              sx, sy;
        int              dx[5] = '{0, 1, 0, -1, 0};
        int              dy[5] = '{0, 0, 1, 0, -1};
        cap = 64'h7FFF_FFFF_FFFF_FFFF;
        total = 0;
        for (int c = 0; c < NCELL; c++) begin
            acc = 0;
            for (int p = 0; p < NPOP; p++) acc += longint'(fpop[p][c]);
            rho_grid[c] = clamp32(acc);
        end
        for (int c = 0; c < NCELL; c++) begin
            rho = rho_grid[c];
            for (int p = 0; p < NPOP; p++) begin
                f = fpop[p][c];
                w8 = (p == 0) ? 4 : 1;
                acc = f * 8 * 65536 + (w8 * rho - 8 * f) * longint'({1'b0, tau_rate})
                    + longint'(src_grid[c]) * w8 * 65536;
                // round to nearest, ties up, then drop 19 fraction bits
                fpop[p][c] = clamp32((acc + (64'sd1 << 18)) >>> 19);
            end
        end
        for (int p = 1; p < NPOP; p++) begin
            for (int y = 0; y < NY; y++) begin
                for (int x = 0; x < NX; x++) begin
                    sx = (x - dx[p] + NX) % NX;
                    sy = (y - dy[p] + NY) % NY;
                    fnext[y * NX + x] = fpop[p][sy * NX + sx];
                end
            end
            for (int c = 0; c < NCELL; c++) fpop[p][c] = fnext[c];
        end
        for (int c = 0; c < NCELL; c++) begin
            diff = longint'(rho_grid[c]) - longint'(rho_past[c]);
            mag = (diff < 0) ? longint'(-diff) : diff;
            sq = mag * mag;
            if (sq > cap - total) total = cap;
            else total += sq;
            rho_past[c] = rho_grid[c];
        end
        return total[62:0];
    endfunction

    // apply one accepted request word to the shadow state
    function automatic ack_t predict_ack(logic [1:0] kind, logic [5:0] cx, logic [5:0] cy,
                                         logic signed [31:0] sv);
        ack_t a;
        int   cell_idx;
        cell_idx = int'(cy) * NX + int'(cx);
        a.kind = kind;
        a.dens = '0;
        a.err = '0;
        case (kind)
            KIND_WRITE: src_grid[cell_idx] = sv;
            KIND_ITER:  a.err = lattice_step();
            KIND_READ:  a.dens = rho_grid[cell_idx];
            default:    wipe_lattice();
        endcase
        return a;
    endfunction

    // drive one request word and wait for it to be taken
    task automatic send_word(logic [1:0] kind, logic [5:0] cx, logic [5:0] cy,
                             logic signed [31:0] sv);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req_type <= kind;
        s_cell_x <= cx;
        s_cell_y <= cy;
        s_source_value <= sv;
        do @(posedge aclk); while (!s_ready);
        ack_q.push_back(predict_ack(kind, cx, cy, sv));
        if (kind == KIND_WRITE) hot_cells.push_back(int'(cy) * NX + int'(cx));
        if (hot_cells.size() > 16) void'(hot_cells.pop_front());
    endtask

    task automatic drain();
        @(posedge aclk);
        s_valid <= 1'b0;
        while (ack_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // register write over apb, only while the block is idle
    task automatic set_inv_tau(logic [16:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= '0;
        pwdata <= {15'd0, v};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        tau_rate = v;
        @(posedge aclk);
    endtask

    // check each result word against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (ack_q.size() == 0) begin
                $display("%0t: unexpected word kind=%0d dens=%0d err=%0d", $realtime,
                         m_ack_kind, m_density_value, m_error_total);
                fail_count++;
            end else begin
                ack_t e;
                e = ack_q.pop_front();
                if (m_ack_kind !== e.kind) begin
                    $display("%0t: ack_kind expected %0d actual %0d", $realtime,
                             e.kind, m_ack_kind);
                    fail_count++;
                end
                if (m_density_value !== e.dens) begin
                    $display("%0t: density_value expected %0d actual %0d", $realtime,
                             $signed(e.dens), m_density_value);
                    fail_count++;
                end
                if (m_error_total !== e.err) begin
                    $display("%0t: error_total expected %0d actual %0d", $realtime,
                             e.err, m_error_total);
                    fail_count++;
                end
            end
        end
    end

    // receiver: random stalls, plus a long hold counted here
    always @(posedge aclk) begin
        if (recv_hold > 0) begin
            recv_hold <= recv_hold - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** lattice_boltzmann_d2q5_step: FAILED **");
            $finish;
        end
    end

    // corners, sign extremes, every request kind, saturation
    task automatic test_directed();
        send_word(KIND_READ, 6'd0, 6'd0, 0);
        send_word(KIND_ITER, 6'd0, 6'd0, 0);
        send_word(KIND_WRITE, 6'd0, 6'd0, 32'sh7FFF_FFFF);
        send_word(KIND_WRITE, 6'd63, 6'd63, 32'sh8000_0000);
        send_word(KIND_WRITE, 6'd63, 6'd0, 32'sh0001_0000);
        send_word(KIND_WRITE, 6'd0, 6'd63, -32'sh0000_8000);
        send_word(KIND_ITER, 6'd0, 6'd0, 0);
        send_word(KIND_ITER, 6'd63, 6'd63, 0);
        send_word(KIND_READ, 6'd0, 6'd0, 0);
        send_word(KIND_READ, 6'd63, 6'd63, 0);
        send_word(KIND_READ, 6'd1, 6'd0, 0);
        send_word(KIND_READ, 6'd0, 6'd63, 0);
        // full swing between iterations should pin the error total
        send_word(KIND_WRITE, 6'd0, 6'd0, 32'sh8000_0000);
        send_word(KIND_WRITE, 6'd63, 6'd63, 32'sh7FFF_FFFF);
        send_word(KIND_ITER, 6'd0, 6'd0, 0);
        send_word(KIND_READ, 6'd63, 6'd63, 0);
        send_word(KIND_CLEAR, 6'd0, 6'd0, 0);
        send_word(KIND_READ, 6'd0, 6'd0, 0);
        send_word(KIND_ITER, 6'd0, 6'd0, 0);
        send_word(KIND_READ, 6'd0, 6'd0, 0);
        drain();
    endtask

    // relaxation rate extremes, including zero and the top value
    task automatic test_inv_tau();
        logic [16:0] rates[3] = '{17'd0, 17'd131071, 17'd32768};
        foreach (rates[i]) begin
            set_inv_tau(rates[i]);
            send_word(KIND_CLEAR, 6'd0, 6'd0, 0);
            send_word(KIND_WRITE, 6'($urandom), 6'($urandom), 32'($urandom));
            send_word(KIND_ITER, 6'd0, 6'd0, 0);
            send_word(KIND_ITER, 6'd0, 6'd0, 0);
            send_word(KIND_READ, 6'($urandom), 6'($urandom), 0);
            drain();
        end
        set_inv_tau(INV_TAU_RESET);
    endtask

    task automatic random_word();
        int          pick, cell_idx;
        logic [31:0] sv;
        pick = $urandom_range(99);
        sv = ($urandom_range(3) == 0) ? 32'($urandom) : 32'($signed($urandom_range(262143)) - 131072);
        if (pick < 40) begin
            send_word(KIND_WRITE, 6'($urandom), 6'($urandom), sv);
        end else if (pick < 50) begin
            send_word(KIND_ITER, 6'($urandom), 6'($urandom), 32'($urandom));
        end else if (pick < 97) begin
            if (hot_cells.size() != 0 && $urandom_range(3) != 0) begin
                // a moved neighbor of a source cell is usually live after streaming
                cell_idx = hot_cells[$urandom_range(hot_cells.size() - 1)];
                send_word(KIND_READ, 6'((cell_idx % NX) + $urandom_range(2) - 1),
                          6'((cell_idx / NX) + $urandom_range(2) - 1), 32'($urandom));
            end else begin
                send_word(KIND_READ, 6'($urandom), 6'($urandom), 32'($urandom));
            end
        end else begin
            send_word(KIND_CLEAR, 6'($urandom), 6'($urandom), 32'($urandom));
        end
    endtask

    task automatic test_random(int n, int s_pct, int r_pct);
        send_idle = s_pct;
        recv_idle = r_pct;
        repeat (n) random_word();
        drain();
    endtask

    // receiver stops long enough for the block to fill and stall requests
    task automatic test_backpressure();
        send_idle = 0;
        recv_idle = 0;
        recv_hold = 400;
        repeat (8) send_word(KIND_READ, 6'($urandom), 6'($urandom), 0);
        send_word(KIND_WRITE, 6'($urandom), 6'($urandom), 32'($urandom));
        // sender waits here until every result has come
        drain();
        send_word(KIND_READ, 6'($urandom), 6'($urandom), 0);
        drain();
    endtask

    initial begin
        for (int c = 0; c < NCELL; c++) src_grid[c] = 0;
        wipe_lattice();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_inv_tau();
        test_random(20, 20, 62);
        set_inv_tau(17'd98304);
        test_random(20, 62, 20);
        set_inv_tau(17'd65536);
        test_random(20, 0, 0);
        test_backpressure();
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("** lattice_boltzmann_d2q5_step: PASSED **");
        end else begin
            $display("** lattice_boltzmann_d2q5_step: FAILED **");
        end
        $finish;
    end

endmodule
